// ----- rtl/srt_pkg.sv -----
// Shared types and constants for the key-ordered record sorter.
`timescale 1ns / 1ps

package srt_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned KEY_W = 32;
  localparam int unsigned IDX_W = 5;

  // Defaults for the top-level parameters.
  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned KEY_BITS_DEF = 32;

  // Controller states: loading records, scanning the store, giving one result.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // store the accepted record, or note it as dropped
    logic start_scan;  // clear the read pointer and the running minimum
    logic scan_run;    // step the scan through the stored records
    logic emit;        // present the running minimum as a result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;    // every stored record has been compared
    logic last_result;  // the result now being given ends the batch
  } sts_t;

endpackage

// ----- rtl/srt_ctrl.sv -----
// Controller state machine of the key-ordered record sorter.
`timescale 1ns / 1ps

module srt_ctrl
  import srt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic batch_last_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic result_valid_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          if (batch_last_i) begin
            cmd_o.start_scan = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.start_scan = 1'b1;
        result_valid_o   = 1'b1;
        state_d          = sts_i.last_result ? ST_LOAD : ST_SCAN;
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

`ifndef SYNTH
  // A result strobe always lasts a single cycle, as a scan or the load state follows each one.
  a_strobe_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");
`endif

endmodule

// ----- rtl/srt_datapath.sv -----
// Datapath of the key-ordered record sorter: record memory, scan and minimum search.
`timescale 1ns / 1ps

module srt_datapath
  import srt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [KEY_W-1:0] sort_key_i,
  input  logic [IDX_W-1:0] payload_index_i,
  output sts_t             sts_o,
  output logic [KEY_W-1:0] sorted_key_o,
  output logic [IDX_W-1:0] sorted_index_o,
  output logic             run_last_o,
  output logic             overflowed_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = KEY_BITS + IDX_W;

  // Record memory, no reset: only entries written in this batch are read.
  logic [RW-1:0] mem_q [CAPACITY];

  logic [CW-1:0]       count_q, rd_ptr_q, emitted_q;
  logic                ovf_q, dv_q, best_valid_q, last_valid_q;
  logic [RW-1:0]       rd_q;
  logic [AW-1:0]       pos_q;
  logic [KEY_BITS-1:0] best_key_q, last_key_q;
  logic [IDX_W-1:0]    best_idx_q;
  logic [AW-1:0]       best_pos_q, last_pos_q;

  logic                      full, issue, above_last, better, take;
  logic [KEY_BITS-1:0]       key_in, rd_key;
  logic [KEY_BITS+KEY_W-1:0] key_in_ext;
  logic [KEY_W+KEY_BITS-1:0] key_out_ext;

  // Key width conversion between the port and the stored record.
  assign key_in_ext  = {{KEY_BITS{1'b0}}, sort_key_i};
  assign key_in      = key_in_ext[KEY_BITS-1:0];
  assign key_out_ext = {{KEY_W{1'b0}}, best_key_q};

  assign full   = (count_q >= CW'(CAPACITY));
  assign issue  = cmd_i.scan_run && (rd_ptr_q < count_q);
  assign rd_key = rd_q[RW-1:IDX_W];

  // Order is by key and then by arrival position, which keeps equal keys stable.
  assign above_last = !last_valid_q || ({rd_key, pos_q} > {last_key_q, last_pos_q});
  assign better     = !best_valid_q || ({rd_key, pos_q} < {best_key_q, best_pos_q});
  assign take       = dv_q && above_last && better;

  // Memory write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !full) begin
      mem_q[count_q[AW-1:0]] <= {key_in, payload_index_i};
    end
    if (issue) begin
      rd_q  <= mem_q[rd_ptr_q[AW-1:0]];
      pos_q <= rd_ptr_q[AW-1:0];
    end
  end

  // Control registers: fill count, overflow, scan pointer and valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      rd_ptr_q     <= '0;
      dv_q         <= 1'b0;
      best_valid_q <= 1'b0;
      last_valid_q <= 1'b0;
      emitted_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        if (full) begin
          ovf_q <= 1'b1;
        end else begin
          count_q <= count_q + CW'(1);
        end
      end
      if (cmd_i.start_scan) begin
        rd_ptr_q     <= '0;
        dv_q         <= 1'b0;
        best_valid_q <= 1'b0;
      end else begin
        dv_q <= issue;
        if (issue) begin
          rd_ptr_q <= rd_ptr_q + CW'(1);
        end
        if (take) begin
          best_valid_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        if (sts_o.last_result) begin
          count_q      <= '0;
          ovf_q        <= 1'b0;
          last_valid_q <= 1'b0;
          emitted_q    <= '0;
        end else begin
          last_valid_q <= 1'b1;
          emitted_q    <= emitted_q + CW'(1);
        end
      end
    end
  end

  // Running minimum and the record last given out.
  always_ff @(posedge clk_i) begin
    if (!cmd_i.start_scan && take) begin
      best_key_q <= rd_key;
      best_idx_q <= rd_q[IDX_W-1:0];
      best_pos_q <= pos_q;
    end
    if (cmd_i.emit) begin
      last_key_q <= best_key_q;
      last_pos_q <= best_pos_q;
    end
  end

  // Status and result fields.
  assign sts_o.scan_done   = (rd_ptr_q == count_q) && !dv_q;
  assign sts_o.last_result = ((emitted_q + CW'(1)) == count_q);
  assign sorted_key_o      = key_out_ext[KEY_W-1:0];
  assign sorted_index_o    = best_idx_q;
  assign run_last_o        = sts_o.last_result;
  assign overflowed_o      = ovf_q;

`ifndef SYNTH
  // A result is only given once the scan has found a record.
  a_emit_has_best : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> best_valid_q)
    else $error("result given without a found record");

  // The fill count never passes the store capacity.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("record count beyond capacity");

  // The final result of a batch empties the store and clears the overflow flag.
  a_batch_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && sts_o.last_result |=> (count_q == '0) && !ovf_q)
    else $error("store not cleared after the final result");
`endif

endmodule

// ----- rtl/sort_entries_by_key_top.sv -----
// Top level of the key-ordered record sorter.
`timescale 1ns / 1ps

// Records (key and payload index) are taken one per cycle while busy_o is low,
// at each edge where start_i is high; the record with batch_last_i high ends the
// batch. Records beyond CAPACITY are dropped and every result of that batch then
// has overflowed_o set. After the last record busy_o rises and the n stored
// records come back in ascending key order, equal keys in arrival order, one per
// result_valid_o strobe of a single cycle, with run_last_o on the final one.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// For each result the single read port of the record memory is swept once over
// all n records to find the next smallest: the n reads, the compare of the last
// record read, a check that the scan has finished, and then the result is given.
// busy_o falls again after the final result of the batch.
module sort_entries_by_key_top
  import srt_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [KEY_W-1:0] sort_key_i,
  input  logic [IDX_W-1:0] payload_index_i,
  input  logic             batch_last_i,
  output logic             result_valid_o,
  output logic [KEY_W-1:0] sorted_key_o,
  output logic [IDX_W-1:0] sorted_index_o,
  output logic             run_last_o,
  output logic             overflowed_o
);

  cmd_t cmd;
  sts_t sts;

  // Controller.
  srt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .batch_last_i   (batch_last_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o)
  );

  // Datapath.
  srt_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sort_key_i      (sort_key_i),
    .payload_index_i (payload_index_i),
    .sts_o           (sts),
    .sorted_key_o    (sorted_key_o),
    .sorted_index_o  (sorted_index_o),
    .run_last_o      (run_last_o),
    .overflowed_o    (overflowed_o)
  );

endmodule
